// ===== src/cgcc_pkg.sv =====
package cgcc_pkg;

  localparam int TILE_SHIFT_DEF     = 7;
  localparam int TILES_PER_CELL_DEF = 8;

  localparam int GRID_MAX    = 64;
  localparam int RADIUS_MAX  = 3072;
  localparam int MAX_RESULTS = 49;

  localparam int POS_W      = 16;
  localparam int GRID_W     = 7;
  localparam int RADIUS_W   = 12;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [GRID_W-1:0]   GRID_RESET   = 7'd32;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH       = 2'd0,
    REG_GRID_HEIGHT      = 2'd1,
    REG_INFLUENCE_RADIUS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [GRID_W-1:0]     grid_width;
    logic [GRID_W-1:0]     grid_height;
    logic [RADIUS_W-1:0]   radius;
    logic [2*RADIUS_W-1:0] radius_sq;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] min_col;
    logic [IDX_W-1:0] max_col;
    logic [IDX_W-1:0] min_row;
    logic [IDX_W-1:0] max_row;
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
  } box_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic             last;
  } cand_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             hit;
    logic             last;
  } res_t;

endpackage

// ===== src/cgcc_cfg_if.sv =====
interface cgcc_cfg_if import cgcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cgcc_pos_if.sv =====
interface cgcc_pos_if import cgcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  modport source (output valid, pos_x, pos_y, input ready);
  modport sink (input valid, pos_x, pos_y, output ready);
endinterface

// ===== src/cgcc_cov_if.sv =====
interface cgcc_cov_if import cgcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_col;
  logic [IDX_W-1:0] cell_row;
  logic             last_cell;

  modport source (output valid, cell_col, cell_row, last_cell, input ready);
  modport sink (input valid, cell_col, cell_row, last_cell, output ready);
endinterface

// ===== src/cgcc_box.sv =====
module cgcc_box import cgcc_pkg::*; #(
  parameter int TILE_SHIFT     = TILE_SHIFT_DEF,
  parameter int TILES_PER_CELL = TILES_PER_CELL_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             conf,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [POS_W-1:0] in_x,
  input  logic [POS_W-1:0] in_y,
  output logic             out_valid,
  input  logic             out_ready,
  output box_t             out_box
);

  localparam int TILE_SIZE  = 1 << TILE_SHIFT;
  localparam int SUM_W      = POS_W + 1;
  localparam int TW         = SUM_W - TILE_SHIFT;
  localparam int RECIP_W    = TW + 1;
  localparam int PROD_W     = TW + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << TW) / TILES_PER_CELL);

  logic s1_v, s2_v, s3_v;
  logic en1, en2, en3, en4;

  logic [POS_W-1:0] cx, cy;
  logic [SUM_W-1:0] edge_val [4];
  logic [3:0]       neg;

  logic [TW-1:0]    s1_tile [4];
  logic [3:0]       s1_neg;
  logic [POS_W-1:0] s1_cx, s1_cy;

  logic [TW-1:0]    s2_tile [4];
  logic [TW-1:0]    s2_q0 [4];
  logic [3:0]       s2_neg;
  logic [POS_W-1:0] s2_cx, s2_cy;

  logic [TW-1:0]    rem [4];
  logic [TW-1:0]    s3_q [4];
  logic [3:0]       s3_neg;
  logic [POS_W-1:0] s3_cx, s3_cy;

  logic [TW-1:0] gw_q, gh_q;
  logic [TW-1:0] min_col, max_col, min_row, max_row;
  logic          empty;

  assign en4      = !out_valid || out_ready;
  assign en3      = !s3_v || en4;
  assign en2      = !s2_v || en3;
  assign en1      = !s1_v || en2;
  assign in_ready = en1;

  always_comb begin
    cx = (in_x & ~POS_W'(TILE_SIZE - 1)) | POS_W'(TILE_SIZE / 2);
    cy = (in_y & ~POS_W'(TILE_SIZE - 1)) | POS_W'(TILE_SIZE / 2);
    edge_val[0] = SUM_W'(cx) - SUM_W'(conf.radius);
    edge_val[1] = SUM_W'(cx) + SUM_W'(conf.radius);
    edge_val[2] = SUM_W'(cy) - SUM_W'(conf.radius);
    edge_val[3] = SUM_W'(cy) + SUM_W'(conf.radius);
    neg[0] = SUM_W'(cx) < SUM_W'(conf.radius);
    neg[1] = 1'b0;
    neg[2] = SUM_W'(cy) < SUM_W'(conf.radius);
    neg[3] = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem[i] = s2_tile[i] - TW'(s2_q0[i] * TW'(TILES_PER_CELL));
    end
  end

  always_comb begin
    gw_q    = TW'(conf.grid_width);
    gh_q    = TW'(conf.grid_height);
    min_col = s3_neg[0] ? '0 : s3_q[0];
    min_row = s3_neg[2] ? '0 : s3_q[2];
    max_col = (s3_q[1] >= gw_q) ? gw_q - TW'(1) : s3_q[1];
    max_row = (s3_q[3] >= gh_q) ? gh_q - TW'(1) : s3_q[3];
    empty   = (gw_q == '0) || (gh_q == '0) || (min_col > max_col) || (min_row > max_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_v <= in_valid;
      if (en2) s2_v <= s1_v;
      if (en3) s3_v <= s2_v;
      if (en4) out_valid <= s3_v && !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 4; i++) begin
        s1_tile[i] <= edge_val[i][SUM_W-1:TILE_SHIFT];
      end
      s1_neg <= neg;
      s1_cx  <= cx;
      s1_cy  <= cy;
    end
    if (en2) begin
      for (int i = 0; i < 4; i++) begin
        s2_tile[i] <= s1_tile[i];
        s2_q0[i]   <= TW'((PROD_W'(s1_tile[i]) * PROD_W'(RECIP)) >> TW);
      end
      s2_neg <= s1_neg;
      s2_cx  <= s1_cx;
      s2_cy  <= s1_cy;
    end
    if (en3) begin
      for (int i = 0; i < 4; i++) begin
        s3_q[i] <= s2_q0[i] + TW'(rem[i] >= TW'(TILES_PER_CELL));
      end
      s3_neg <= s2_neg;
      s3_cx  <= s2_cx;
      s3_cy  <= s2_cy;
    end
    if (en4) begin
      out_box.min_col <= min_col[IDX_W-1:0];
      out_box.max_col <= max_col[IDX_W-1:0];
      out_box.min_row <= min_row[IDX_W-1:0];
      out_box.max_row <= max_row[IDX_W-1:0];
      out_box.cx      <= s3_cx;
      out_box.cy      <= s3_cy;
    end
  end

endmodule

// ===== src/cgcc_walk.sv =====
module cgcc_walk import cgcc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  box_t  in_box,
  output logic  out_valid,
  input  logic  out_ready,
  output cand_t out_cand
);

  logic             busy;
  logic [IDX_W-1:0] col, row, max_col, min_row, max_row;
  logic [POS_W-1:0] cx, cy;
  logic             emit, at_end, load;

  assign in_ready = !busy;
  assign load     = in_valid && !busy;
  assign emit     = busy && (!out_valid || out_ready);
  assign at_end   = (col == max_col) && (row == max_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (emit && at_end) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col     <= in_box.min_col;
      row     <= in_box.min_row;
      max_col <= in_box.max_col;
      min_row <= in_box.min_row;
      max_row <= in_box.max_row;
      cx      <= in_box.cx;
      cy      <= in_box.cy;
    end else if (emit) begin
      if (row == max_row) begin
        col <= col + IDX_W'(1);
        row <= min_row;
      end else begin
        row <= row + IDX_W'(1);
      end
    end
    if (emit) begin
      out_cand.col  <= col;
      out_cand.row  <= row;
      out_cand.cx   <= cx;
      out_cand.cy   <= cy;
      out_cand.last <= at_end;
    end
  end

  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    busy |-> (col <= max_col && row <= max_row))
    else $error("walk position outside box");

endmodule

// ===== src/cgcc_test.sv =====
module cgcc_test import cgcc_pkg::*; #(
  parameter int TILE_SHIFT     = TILE_SHIFT_DEF,
  parameter int TILES_PER_CELL = TILES_PER_CELL_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  conf,
  input  logic  in_valid,
  output logic  in_ready,
  input  cand_t in_cand,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int CELL_UNITS = TILES_PER_CELL << TILE_SHIFT;
  localparam int CW         = $clog2(GRID_MAX * CELL_UNITS + 1);
  localparam int AW         = (CW > POS_W) ? CW : POS_W;
  localparam int DW         = AW + 1;
  localparam int SQ_W       = 2 * RADIUS_W;

  logic t1_v, t2_v, t3_v;
  logic en1, en2, en3, en4;

  logic [AW-1:0]    t1_x1, t1_x2, t1_y1, t1_y2;
  logic [POS_W-1:0] t1_cx, t1_cy;
  logic [IDX_W-1:0] t1_col, t1_row;
  logic             t1_last;

  logic [DW-1:0]       dx1, dx2, dy1, dy2, ndx2, ndy2;
  logic                x_low, x_high, y_low, y_high;
  logic [RADIUS_W-1:0] t2_ax, t2_ay;
  logic                t2_xo, t2_yo;
  logic [IDX_W-1:0]    t2_col, t2_row;
  logic                t2_last;

  logic [SQ_W-1:0]     t3_sqx, t3_sqy;
  logic [RADIUS_W-1:0] t3_ax, t3_ay;
  logic                t3_xo, t3_yo;
  logic [IDX_W-1:0]    t3_col, t3_row;
  logic                t3_last;

  logic [SQ_W:0] sum_sq;
  logic          hit;

  assign en4      = !out_valid || out_ready;
  assign en3      = !t3_v || en4;
  assign en2      = !t2_v || en3;
  assign en1      = !t1_v || en2;
  assign in_ready = en1;

  always_comb begin
    dx1    = DW'(t1_x1) - DW'(t1_cx);
    dx2    = DW'(t1_x2) - DW'(t1_cx);
    dy1    = DW'(t1_y1) - DW'(t1_cy);
    dy2    = DW'(t1_y2) - DW'(t1_cy);
    ndx2   = ~dx2 + DW'(1);
    ndy2   = ~dy2 + DW'(1);
    x_low  = dx2[DW-1];
    x_high = !dx1[DW-1] && (dx1 != '0);
    y_low  = dy2[DW-1];
    y_high = !dy1[DW-1] && (dy1 != '0);
  end

  always_comb begin
    sum_sq = (SQ_W + 1)'(t3_sqx) + (SQ_W + 1)'(t3_sqy);
    if (t3_xo && t3_yo) begin
      hit = sum_sq < (SQ_W + 1)'(conf.radius_sq);
    end else if (t3_xo) begin
      hit = t3_ax < conf.radius;
    end else if (t3_yo) begin
      hit = t3_ay < conf.radius;
    end else begin
      hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v      <= 1'b0;
      t2_v      <= 1'b0;
      t3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) t1_v <= in_valid;
      if (en2) t2_v <= t1_v;
      if (en3) t3_v <= t2_v;
      if (en4) out_valid <= t3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t1_x1   <= AW'(in_cand.col) * AW'(CELL_UNITS);
      t1_x2   <= (AW'(in_cand.col) + AW'(1)) * AW'(CELL_UNITS);
      t1_y1   <= AW'(in_cand.row) * AW'(CELL_UNITS);
      t1_y2   <= (AW'(in_cand.row) + AW'(1)) * AW'(CELL_UNITS);
      t1_cx   <= in_cand.cx;
      t1_cy   <= in_cand.cy;
      t1_col  <= in_cand.col;
      t1_row  <= in_cand.row;
      t1_last <= in_cand.last;
    end
    if (en2) begin
      t2_ax   <= x_low ? ndx2[RADIUS_W-1:0] : dx1[RADIUS_W-1:0];
      t2_ay   <= y_low ? ndy2[RADIUS_W-1:0] : dy1[RADIUS_W-1:0];
      t2_xo   <= x_low || x_high;
      t2_yo   <= y_low || y_high;
      t2_col  <= t1_col;
      t2_row  <= t1_row;
      t2_last <= t1_last;
    end
    if (en3) begin
      t3_sqx  <= SQ_W'(t2_ax) * SQ_W'(t2_ax);
      t3_sqy  <= SQ_W'(t2_ay) * SQ_W'(t2_ay);
      t3_ax   <= t2_ax;
      t3_ay   <= t2_ay;
      t3_xo   <= t2_xo;
      t3_yo   <= t2_yo;
      t3_col  <= t2_col;
      t3_row  <= t2_row;
      t3_last <= t2_last;
    end
    if (en4) begin
      out_res.col  <= t3_col;
      out_res.row  <= t3_row;
      out_res.hit  <= hit;
      out_res.last <= t3_last;
    end
  end

endmodule

// ===== src/cgcc_hold.sv =====
module cgcc_hold import cgcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  res_t       in_res,
  cgcc_cov_if.source cov
);

  localparam int CNT_W = $clog2(MAX_RESULTS);

  logic             pend_valid, flush, drop;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] pend_col, pend_row;
  logic             out_free, take, final_hit;

  assign out_free  = !cov.valid || cov.ready;
  assign in_ready  = out_free && !flush;
  assign take      = in_valid && in_ready;
  assign final_hit = in_res.last || (cnt == CNT_W'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cov.valid  <= 1'b0;
      pend_valid <= 1'b0;
      flush      <= 1'b0;
      drop       <= 1'b0;
      cnt        <= '0;
    end else begin
      if (flush && out_free) begin
        cov.valid  <= 1'b1;
        pend_valid <= 1'b0;
        flush      <= 1'b0;
      end else if (take) begin
        if (drop) begin
          cov.valid <= 1'b0;
          drop      <= !in_res.last;
        end else if (in_res.hit) begin
          cov.valid  <= pend_valid;
          pend_valid <= 1'b1;
          if (final_hit) begin
            flush <= 1'b1;
            drop  <= !in_res.last;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end else if (in_res.last) begin
          cov.valid  <= pend_valid;
          pend_valid <= 1'b0;
          cnt        <= '0;
        end else begin
          cov.valid <= 1'b0;
        end
      end else if (out_free) begin
        cov.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush && out_free) begin
      cov.cell_col  <= pend_col;
      cov.cell_row  <= pend_row;
      cov.last_cell <= 1'b1;
    end else if (take && !drop) begin
      if (in_res.hit) begin
        cov.cell_col  <= pend_col;
        cov.cell_row  <= pend_row;
        cov.last_cell <= 1'b0;
        pend_col      <= in_res.col;
        pend_row      <= in_res.row;
      end else if (in_res.last) begin
        cov.cell_col  <= pend_col;
        cov.cell_row  <= pend_row;
        cov.last_cell <= 1'b1;
      end
    end
  end

  a_flush_has_pend: assert property (@(posedge clk) disable iff (rst)
    flush |-> pend_valid)
    else $error("final flush without a held cell");

  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    drop |-> (flush || !pend_valid))
    else $error("held cell while dropping the rest of a walk");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(MAX_RESULTS))
    else $error("cell count past the result limit");

endmodule

// ===== src/circle_grid_cell_coverage.sv =====
// Channel  Role   Payload                           Transfer
// cfg      sink   index[1:0], data[11:0]            valid && ready (ready always high)
// pos      sink   pos_x[15:0], pos_y[15:0]          valid && ready
// cov      source cell_col[5:0], cell_row[5:0],     valid && ready
//                 last_cell
//
// A position passes four box stages; the walker loads its box, then issues one cell per cycle
// while nothing downstream stalls, (box columns) x (box rows) cells an object, and takes no new
// box until its last cell is out: at most a 6 x 6 box with the reset radius, 7 x 7 at the largest
// radius; marking the final cell fits the gap between two walks.
// Reset is synchronous: valid bits clear, grid 32 x 32, radius 2560.
// cov.ready low holds every stage in place; nothing is lost or repeated.
module circle_grid_cell_coverage import cgcc_pkg::*; #(
  parameter int TILE_SHIFT     = TILE_SHIFT_DEF,
  parameter int TILES_PER_CELL = TILES_PER_CELL_DEF
) (
  input logic        clk,
  input logic        rst,
  cgcc_cfg_if.sink   cfg,
  cgcc_pos_if.sink   pos,
  cgcc_cov_if.source cov
);

  logic [GRID_W-1:0]     grid_width, grid_height;
  logic [RADIUS_W-1:0]   influence_radius;
  logic [2*RADIUS_W-1:0] radius_sq;
  cfg_t                  conf;

  logic  box_valid, box_ready;
  box_t  box;
  logic  cand_valid, cand_ready;
  cand_t cand;
  logic  res_valid, res_ready;
  res_t  res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= GRID_RESET;
      grid_height      <= GRID_RESET;
      influence_radius <= RADIUS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_GRID_WIDTH:       grid_width <= cfg.data[GRID_W-1:0];
        REG_GRID_HEIGHT:      grid_height <= cfg.data[GRID_W-1:0];
        REG_INFLUENCE_RADIUS: influence_radius <= cfg.data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    conf.grid_width  = (grid_width > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_width;
    conf.grid_height = (grid_height > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_height;
    conf.radius      = (influence_radius > RADIUS_W'(RADIUS_MAX)) ?
                       RADIUS_W'(RADIUS_MAX) : influence_radius;
    conf.radius_sq   = radius_sq;
  end

  always_ff @(posedge clk) begin
    radius_sq <= (2*RADIUS_W)'(conf.radius) * (2*RADIUS_W)'(conf.radius);
  end

  cgcc_box #(
    .TILE_SHIFT     (TILE_SHIFT),
    .TILES_PER_CELL (TILES_PER_CELL)
  ) u_box (
    .clk       (clk),
    .rst       (rst),
    .conf      (conf),
    .in_valid  (pos.valid),
    .in_ready  (pos.ready),
    .in_x      (pos.pos_x),
    .in_y      (pos.pos_y),
    .out_valid (box_valid),
    .out_ready (box_ready),
    .out_box   (box)
  );

  cgcc_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (box_valid),
    .in_ready  (box_ready),
    .in_box    (box),
    .out_valid (cand_valid),
    .out_ready (cand_ready),
    .out_cand  (cand)
  );

  cgcc_test #(
    .TILE_SHIFT     (TILE_SHIFT),
    .TILES_PER_CELL (TILES_PER_CELL)
  ) u_test (
    .clk       (clk),
    .rst       (rst),
    .conf      (conf),
    .in_valid  (cand_valid),
    .in_ready  (cand_ready),
    .in_cand   (cand),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_res   (res)
  );

  cgcc_hold u_hold (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_res   (res),
    .cov      (cov)
  );

endmodule
